[sv/sftdm_pkg.sv]
package sftdm_pkg;

	localparam int MATRIX_ROWS = 1024;
	localparam int MAX_RANK    = 16;

	localparam int ROW_W   = 10;
	localparam int COL_W   = 4;
	localparam int RANK_W  = 5;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int SUM_W   = 40;

	// store is split into banks by the low address bits
	localparam int NBANK   = 16;
	localparam int BANK_W  = 4;
	localparam int IDX_W   = 10;
	localparam int ADDR_W  = BANK_W + IDX_W;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(16);
	localparam logic [0:0]        REG_RANK   = 1'b0;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_NONZERO = 1'b1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic                    wr_en;
		logic                    add_en;
		logic                    fend;
		logic [ADDR_W-1:0]       addr;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

[sv/sftdm_front.sv]
module sftdm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 opcode,
	input  logic [sftdm_pkg::ROW_W-1:0]          row_index,
	input  logic [sftdm_pkg::COL_W-1:0]          column_index,
	input  logic signed [sftdm_pkg::VAL_W-1:0]   entry_value,
	input  logic                                 fiber_end,
	input  logic [sftdm_pkg::RANK_W-1:0]         rank,
	input  logic                                 q_pop,
	output logic                                 q_valid,
	output sftdm_pkg::cmd_t                      q_head
);

	sftdm_pkg::cmd_t                       entry_q [sftdm_pkg::QDEPTH];
	logic [sftdm_pkg::QPTR_W-1:0]          wr_ptr_q;
	logic [sftdm_pkg::QPTR_W-1:0]          rd_ptr_q;
	logic [sftdm_pkg::QCNT_W-1:0]          count_q;
	sftdm_pkg::cmd_t                       cmd;
	logic                                  row_ok;
	logic                                  col_ok;
	logic [sftdm_pkg::COL_W-1:0]           col_sel;
	logic [sftdm_pkg::ADDR_W:0]            addr_full;
	logic                                  push_ok;
	logic                                  pop_ok;

	// classify the word and work out its flat store address
	always_comb begin
		row_ok    = 32'(row_index) < sftdm_pkg::MATRIX_ROWS;
		col_ok    = {1'b0, column_index} < rank;
		col_sel   = (opcode == sftdm_pkg::OP_LOAD) ? column_index : '0;
		addr_full = (sftdm_pkg::ADDR_W+1)'(row_index) * (sftdm_pkg::ADDR_W+1)'(rank)
			+ (sftdm_pkg::ADDR_W+1)'(col_sel);
		cmd.addr   = addr_full[sftdm_pkg::ADDR_W-1:0];
		cmd.value  = entry_value;
		cmd.wr_en  = (opcode == sftdm_pkg::OP_LOAD) && row_ok && col_ok;
		cmd.add_en = (opcode == sftdm_pkg::OP_NONZERO) && row_ok;
		cmd.fend   = (opcode == sftdm_pkg::OP_NONZERO) && fiber_end;
	end

	assign full    = count_q == sftdm_pkg::QCNT_W'(sftdm_pkg::QDEPTH);
	assign q_valid = count_q != '0;
	assign q_head  = entry_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sftdm_pkg::QCNT_W'(sftdm_pkg::QDEPTH))
		else $error("command queue count beyond depth");

endmodule

[sv/sftdm_back.sv]
module sftdm_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [sftdm_pkg::RANK_W-1:0]         rank,
	input  logic                                 q_valid,
	input  sftdm_pkg::cmd_t                      q_head,
	output logic                                 q_pop,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [sftdm_pkg::COL_W-1:0]          out_column,
	output logic signed [sftdm_pkg::SUM_W-1:0]   out_sum,
	output logic                                 out_last
);

	localparam int NB = sftdm_pkg::NBANK;
	localparam int MR = sftdm_pkg::MAX_RANK;

	logic [sftdm_pkg::VAL_W-1:0]            store_q [NB][2**sftdm_pkg::IDX_W];

	sftdm_pkg::cmd_t                         cmd_s1;
	sftdm_pkg::cmd_t                         cmd_s2;
	logic                                    v_s1, v_s2, v_s3;
	logic [NB-1:0][sftdm_pkg::VAL_W-1:0]     rd_s2;
	logic [MR-1:0][sftdm_pkg::PROD_W-1:0]    prod_s3;
	logic                                    add_s3;
	logic                                    end_s3;

	logic [MR-1:0][sftdm_pkg::SUM_W-1:0]     acc_q;
	logic [MR-1:0][sftdm_pkg::SUM_W-1:0]     acc_nxt;
	logic [MR-1:0][sftdm_pkg::SUM_W-1:0]     emit_buf_q;
	logic [sftdm_pkg::RANK_W-1:0]            emit_cnt_q;
	logic [sftdm_pkg::COL_W-1:0]             emit_idx_q;
	logic [sftdm_pkg::RANK_W-1:0]            emit_rank_q;

	logic                                    advance;
	logic                                    emit_load;
	logic [NB-1:0][sftdm_pkg::IDX_W-1:0]     rd_idx;
	logic [sftdm_pkg::BANK_W-1:0]            base_lo_s1;
	logic [sftdm_pkg::IDX_W-1:0]             base_hi_s1;
	logic [MR-1:0][sftdm_pkg::PROD_W-1:0]    prod;

	// hold the whole pipe while a fiber end waits for the emit buffer
	assign advance   = !(v_s3 && end_s3 && (emit_cnt_q != '0));
	assign q_pop     = advance && q_valid;
	assign emit_load = advance && v_s3 && end_s3;

	// consecutive addresses fall in distinct banks; wrap into next index
	always_comb begin
		base_lo_s1 = cmd_s1.addr[sftdm_pkg::BANK_W-1:0];
		base_hi_s1 = cmd_s1.addr[sftdm_pkg::ADDR_W-1:sftdm_pkg::BANK_W];
		for (int b = 0; b < NB; b++) begin
			rd_idx[b] = base_hi_s1
				+ sftdm_pkg::IDX_W'(sftdm_pkg::BANK_W'(b) < base_lo_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int b = 0; b < NB; b++) begin
				if (v_s1 && cmd_s1.wr_en && (base_lo_s1 == sftdm_pkg::BANK_W'(b))) begin
					store_q[b][base_hi_s1] <= cmd_s1.value;
				end
				rd_s2[b] <= store_q[b][rd_idx[b]];
			end
		end
	end

	// rotate bank outputs back to column order, one multiplier per column
	always_comb begin
		logic [sftdm_pkg::BANK_W-1:0] sel;
		for (int c = 0; c < MR; c++) begin
			sel     = cmd_s2.addr[sftdm_pkg::BANK_W-1:0] + sftdm_pkg::BANK_W'(c);
			prod[c] = $signed(cmd_s2.value) * $signed(rd_s2[sel]);
		end
	end

	// saturating accumulate on columns in use
	always_comb begin
		logic signed [sftdm_pkg::SUM_W:0] ext;
		for (int c = 0; c < MR; c++) begin
			ext = $signed({acc_q[c][sftdm_pkg::SUM_W-1], acc_q[c]})
				+ $signed({{(sftdm_pkg::SUM_W+1-sftdm_pkg::PROD_W){prod_s3[c][sftdm_pkg::PROD_W-1]}},
					prod_s3[c]});
			if (add_s3 && (sftdm_pkg::RANK_W'(c) < rank)) begin
				if (ext[sftdm_pkg::SUM_W] != ext[sftdm_pkg::SUM_W-1]) begin
					acc_nxt[c] = ext[sftdm_pkg::SUM_W] ? sftdm_pkg::SUM_MIN : sftdm_pkg::SUM_MAX;
				end else begin
					acc_nxt[c] = ext[sftdm_pkg::SUM_W-1:0];
				end
			end else begin
				acc_nxt[c] = acc_q[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (q_valid) begin
				cmd_s1 <= q_head;
			end
			cmd_s2  <= cmd_s1;
			prod_s3 <= prod;
			add_s3  <= cmd_s2.add_en;
			end_s3  <= cmd_s2.fend;
		end
		if (emit_load) begin
			emit_buf_q <= acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			acc_q       <= '0;
			emit_cnt_q  <= '0;
			emit_idx_q  <= '0;
			emit_rank_q <= '0;
		end else begin
			if (advance) begin
				v_s1 <= q_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (v_s3) begin
					acc_q <= end_s3 ? '0 : acc_nxt;
				end
			end
			if (emit_load) begin
				emit_cnt_q  <= rank;
				emit_idx_q  <= '0;
				emit_rank_q <= rank;
			end else if (pop && !empty) begin
				emit_cnt_q <= emit_cnt_q - 1'b1;
				emit_idx_q <= emit_idx_q + 1'b1;
			end
		end
	end

	assign empty      = emit_cnt_q == '0;
	assign out_column = emit_idx_q;
	assign out_sum    = emit_buf_q[emit_idx_q];
	assign out_last   = emit_cnt_q == sftdm_pkg::RANK_W'(1);

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> acc_q == '0)
		else $error("accumulators not cleared after fiber end");

	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (emit_idx_q == '0) && (emit_cnt_q == emit_rank_q))
		else $error("emission did not start at column zero");

	a_emit_track: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_cnt_q != '0) |-> ((sftdm_pkg::RANK_W'(emit_idx_q) + emit_cnt_q) == emit_rank_q))
		else $error("emit index and count out of step");

endmodule

[sv/sparse_fiber_times_dense_matrix_unit.sv]
// Sparse fiber times dense matrix unit.
// Input channel (push/full): one word per cycle unless full. opcode 0 loads
// one Q4.12 matrix entry at row_index/column_index; opcode 1 carries a tensor
// nonzero (entry_value, row_index) and fiber_end marks the last nonzero of a
// fiber. Result channel (empty/pop): on a fiber end the unit emits one word
// per column in use, out_column 0 upward, each a saturated 40-bit column sum,
// with out_last on the final column. Accumulators clear after the fiber end.
// Throughput: one input word per cycle unless full; all columns multiply in
// parallel. A fiber end occupies the emit buffer until its words are popped;
// a following fiber end waits in the pipe until that buffer has drained. A
// fiber end reaches the result ports through the queue, store read, multiply
// and accumulate steps. The 4-word command queue between classifier and
// datapath absorbs short stalls; when the receiver stops popping, the pipe
// holds, the queue fills and full rises.
// Reset clears the queue, pipeline valids, accumulators and emitter and sets
// rank_in_use to 16; the matrix store holds nothing meaningful until loaded.
// Configuration: APB register 0 (byte address 0) is rank_in_use; write it
// only while no work is in flight.
module sparse_fiber_times_dense_matrix_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 opcode,
	input  logic [sftdm_pkg::ROW_W-1:0]          row_index,
	input  logic [sftdm_pkg::COL_W-1:0]          column_index,
	input  logic signed [sftdm_pkg::VAL_W-1:0]   entry_value,
	input  logic                                 fiber_end,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [sftdm_pkg::COL_W-1:0]          out_column,
	output logic signed [sftdm_pkg::SUM_W-1:0]   out_sum,
	output logic                                 out_last,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sftdm_pkg::PADDR_W-1:0]        paddr,
	input  logic [sftdm_pkg::PDATA_W-1:0]        pwdata,
	output logic [sftdm_pkg::PDATA_W-1:0]        prdata,
	output logic                                 pready
);

	logic [sftdm_pkg::RANK_W-1:0] rank_q;
	logic [sftdm_pkg::RANK_W-1:0] rank_eff;
	logic                         reg_hit;
	logic                         q_valid;
	logic                         q_pop;
	sftdm_pkg::cmd_t              q_head;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2:2] == sftdm_pkg::REG_RANK;

	// register write lands on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= sftdm_pkg::RANK_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			rank_q <= pwdata[sftdm_pkg::RANK_W-1:0];
		end
	end

	assign prdata = reg_hit ? sftdm_pkg::PDATA_W'(rank_q) : '0;

	// zero acts as one column, anything past the maximum as the maximum
	always_comb begin
		if (rank_q == '0) begin
			rank_eff = sftdm_pkg::RANK_W'(1);
		end else if (32'(rank_q) > sftdm_pkg::MAX_RANK) begin
			rank_eff = sftdm_pkg::RANK_W'(sftdm_pkg::MAX_RANK);
		end else begin
			rank_eff = rank_q;
		end
	end

	sftdm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.fiber_end    (fiber_end),
		.rank         (rank_eff),
		.q_pop        (q_pop),
		.q_valid      (q_valid),
		.q_head       (q_head)
	);

	sftdm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rank       (rank_eff),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_column (out_column),
		.out_sum    (out_sum),
		.out_last   (out_last)
	);

endmodule

[test/column_sum_tracker_pkg.sv]
package column_sum_tracker_pkg;

	import sftdm_pkg::*;

	typedef struct packed {
		logic                    opcode;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		logic                    fend;
	} tensor_word_t;

	typedef struct packed {
		logic [COL_W-1:0]        col;
		logic signed [SUM_W-1:0] total;
		logic                    is_last;
	} column_sum_t;

	// Mirror of the matrix store and column accumulators; keeps the column
	// sums still owed by the unit in arrival order.
	class column_sum_tracker;
		int unsigned             fails;
		logic [RANK_W-1:0]       rank_reg;
		logic signed [VAL_W-1:0] matrix_copy [MATRIX_ROWS*MAX_RANK];
		longint                  running_sums [MAX_RANK];
		column_sum_t             due_sums [$];

		function new();
			fails = 0;
			rank_reg = RANK_RESET;
			foreach (running_sums[i]) running_sums[i] = 0;
		endfunction

		function void set_rank(logic [RANK_W-1:0] v);
			rank_reg = v;
		endfunction

		function int active_rank();
			if (rank_reg == 0) return 1;
			if (int'(rank_reg) > MAX_RANK) return MAX_RANK;
			return int'(rank_reg);
		endfunction

		function int sums_due();
			return due_sums.size();
		endfunction

		function longint clamp_sum(longint s);
			if (s > longint'(SUM_MAX)) return longint'(SUM_MAX);
			if (s < longint'(SUM_MIN)) return longint'(SUM_MIN);
			return s;
		endfunction

		function void note_word(tensor_word_t w);
			int          span;
			int          base;
			longint      prod;
			column_sum_t owed;
			span = active_rank();
			base = int'(w.row) * span;
			if (w.opcode == OP_LOAD) begin
				if (int'(w.col) < span) matrix_copy[base + int'(w.col)] = w.value;
				return;
			end
			for (int c = 0; c < span; c++) begin
				prod = longint'($signed(w.value)) * longint'($signed(matrix_copy[base + c]));
				running_sums[c] = clamp_sum(running_sums[c] + prod);
			end
			if (w.fend) begin
				for (int c = 0; c < span; c++) begin
					owed.col = COL_W'(c);
					owed.total = running_sums[c][SUM_W-1:0];
					owed.is_last = (c == span - 1);
					due_sums.push_back(owed);
				end
				foreach (running_sums[i]) running_sums[i] = 0;
			end
		endfunction

		function void check_word(logic [COL_W-1:0] col, logic signed [SUM_W-1:0] total,
				logic is_last);
			column_sum_t want;
			if (due_sums.size() == 0) begin
				$error("result word with none due: out_column %0d out_sum %0d out_last %0d",
					col, total, is_last);
				fails++;
				return;
			end
			want = due_sums.pop_front();
			if (col !== want.col) begin
				$error("out_column: expected %0d, got %0d", want.col, col);
				fails++;
			end
			if (total !== want.total) begin
				$error("out_sum: expected %0d, got %0d", want.total, total);
				fails++;
			end
			if (is_last !== want.is_last) begin
				$error("out_last: expected %0d, got %0d", want.is_last, is_last);
				fails++;
			end
		endfunction
	endclass

endpackage

[test/sparse_fiber_times_dense_matrix_unit_test.sv]
module sparse_fiber_times_dense_matrix_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import sftdm_pkg::*;
	import column_sum_tracker_pkg::*;

	// Pipe stages plus a 4-word command queue; give them room to go quiet.
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_WORDS   = 12;
	localparam int PHASE_COUNT   = 6;
	localparam int POOL_ROWS     = 2;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
	localparam logic [PADDR_W-1:0] RANK_ADDR = PADDR_W'(4 * REG_RANK);

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic                    full;
	logic                    opcode = OP_LOAD;
	logic [ROW_W-1:0]        row_index = '0;
	logic [COL_W-1:0]        column_index = '0;
	logic signed [VAL_W-1:0] entry_value = '0;
	logic                    fiber_end = 1'b0;
	logic                    empty;
	logic                    pop = 1'b0;
	logic [COL_W-1:0]        out_column;
	logic signed [SUM_W-1:0] out_sum;
	logic                    out_last;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [PADDR_W-1:0]      paddr = '0;
	logic [PDATA_W-1:0]      pwdata = '0;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;

	column_sum_tracker tracker;
	int tx_gap_max = 7;
	int rx_gap_max = 7;

	sparse_fiber_times_dense_matrix_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.fiber_end    (fiber_end),
		.empty        (empty),
		.pop          (pop),
		.out_column   (out_column),
		.out_sum      (out_sum),
		.out_last     (out_last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic tensor_word_t make_load(int row, int col, logic signed [VAL_W-1:0] v,
			logic fend);
		tensor_word_t w;
		w.opcode = OP_LOAD;
		w.row = ROW_W'(row);
		w.col = COL_W'(col);
		w.value = v;
		w.fend = fend;
		return w;
	endfunction

	// Column index means nothing on a nonzero; toggle it anyway.
	function automatic tensor_word_t make_nonzero(int row, logic signed [VAL_W-1:0] v,
			logic fend);
		tensor_word_t w;
		w.opcode = OP_NONZERO;
		w.row = ROW_W'(row);
		w.col = COL_W'($urandom);
		w.value = v;
		w.fend = fend;
		return w;
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	// Keep push high between back-to-back words, drop it only for a gap.
	task automatic send_word(input tensor_word_t w);
		int gap;
		gap = $urandom_range(tx_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		opcode <= w.opcode;
		row_index <= w.row;
		column_index <= w.col;
		entry_value <= w.value;
		fiber_end <= w.fend;
		@(posedge clk);
		while (full) @(posedge clk);
		tracker.note_word(w);
		@(negedge clk);
	endtask

	// Hold the sender until every owed sum has been popped, then let any
	// result-free words still in the pipe drain out.
	task automatic settle();
		push <= 1'b0;
		while (tracker.sums_due() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write rank_in_use over APB, then read it back. Only call while idle.
	task automatic program_rank(input logic [RANK_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RANK_ADDR;
		pwdata <= {(PDATA_W-RANK_W)'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.set_rank(v);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[RANK_W-1:0] !== v) begin
			$error("rank_in_use: expected %0d, got %0d", v, prdata[RANK_W-1:0]);
			tracker.fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: pop with random stalls, switching between stalling and
	// streaming every few dozen words.
	initial begin
		int stall;
		int count;
		count = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (count % 32 == 0) rx_gap_max = ($urandom_range(3) == 0) ? 0 : 7;
			count++;
			stall = $urandom_range(rx_gap_max);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			tracker.check_word(out_column, out_sum, out_last);
			@(negedge clk);
		end
	end

	initial begin
		int span;
		int rows [POOL_ROWS];
		logic [RANK_W-1:0] phase_rank;

		tracker = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: rank 2, full-scale entries in the first and last rows.
		program_rank(RANK_W'(2));
		send_word(make_load(0, 0, VAL_MAX, 1'b0));
		send_word(make_load(0, 1, VAL_MIN, 1'b0));
		send_word(make_load(MATRIX_ROWS - 1, 0, VAL_MIN, 1'b0));
		// fiber end on a load must be ignored
		send_word(make_load(MATRIX_ROWS - 1, 1, 16'sd1, 1'b1));
		// loads past the rank in use must be dropped
		send_word(make_load(0, 15, 16'sd1234, 1'b0));
		send_word(make_load(MATRIX_ROWS - 1, 2, -16'sd5, 1'b0));
		send_word(make_nonzero(0, VAL_MIN, 1'b0));
		send_word(make_nonzero(MATRIX_ROWS - 1, VAL_MAX, 1'b1));
		send_word(make_nonzero(0, 16'sd0, 1'b1));
		send_word(make_nonzero(MATRIX_ROWS - 1, -16'sd1, 1'b1));
		// leave a fiber open across the rank change below
		send_word(make_nonzero(0, VAL_MAX, 1'b0));
		settle();

		// Rank 0 acts as 1: column 1 of the open fiber is never emitted.
		program_rank(RANK_W'(0));
		send_word(make_load(5, 0, 16'sd100, 1'b0));
		send_word(make_load(5, 1, 16'sd77, 1'b0));
		send_word(make_nonzero(5, 16'sd200, 1'b0));
		send_word(make_nonzero(0, VAL_MIN, 1'b1));
		settle();

		// Random phases: each picks a rank, loads a small pool of rows in
		// full, then mixes overwrites, ignored loads and nonzeros. Phases
		// often stop mid-fiber, so the next rank change lands inside one.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: phase_rank = RANK_W'(MAX_RANK);
				1: phase_rank = RANK_W'(31);
				2: phase_rank = RANK_W'(1);
				3: phase_rank = RANK_W'(MAX_RANK + 1);
				4: phase_rank = RANK_W'($urandom_range(MAX_RANK - 1, 2));
				default: phase_rank = RANK_W'($urandom_range(31));
			endcase
			program_rank(phase_rank);
			span = tracker.active_rank();
			tx_gap_max = ($urandom_range(3) == 0) ? 0 : 7;
			foreach (rows[i])
				rows[i] = ($urandom_range(4) == 0) ?
					(($urandom_range(1) == 1) ? MATRIX_ROWS - 1 : 0) :
					int'($urandom_range(MATRIX_ROWS - 1));
			foreach (rows[i])
				for (int c = 0; c < span; c++)
					send_word(make_load(rows[i], c, pick_value(), 1'($urandom)));
			repeat (PHASE_WORDS) begin
				if ($urandom_range(9) < 3)
					send_word(make_load(rows[$urandom_range(POOL_ROWS - 1)],
						$urandom_range(MAX_RANK - 1), pick_value(), 1'($urandom)));
				else
					send_word(make_nonzero(rows[$urandom_range(POOL_ROWS - 1)],
						pick_value(), $urandom_range(4) == 0));
			end
			settle();
		end

		if (tracker.fails == 0) begin
			$display("sparse_fiber_times_dense_matrix_unit_test passed");
		end else begin
			$display("sparse_fiber_times_dense_matrix_unit_test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("sparse_fiber_times_dense_matrix_unit_test failed");
		$finish;
	end

endmodule
